@@ design/smdc_pkg.sv @@
// ----------------------------------------------------------------------------
// smdc_pkg: shared types and constants for the matrix determinant block
// Widths of the port fields, operation codes, the control word that rides
// along the lane pipeline, and the minor index helpers.
// ----------------------------------------------------------------------------
package smdc_pkg;

  localparam int ELEM_W        = 16;   // port width of one element
  localparam int VALUE_BITS    = 49;   // width of the result value
  localparam int SIZE_W        = 2;    // width of matrix_size and the indexes
  localparam int ELEM_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 12;
  localparam int NUM_LANES     = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 2'd3;

  typedef enum logic {
    OP_DET = 1'b0,
    OP_COF = 1'b1
  } op_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SIZE_W-1:0] size;
    logic              bad;
    logic              neg;
  } ctrl_t;

  // First remaining index once index i is struck out.
  function automatic logic [SIZE_W-1:0] skip_lo(input logic [SIZE_W-1:0] i);
    skip_lo = (i == 2'd0) ? 2'd1 : 2'd0;
  endfunction

  // Second remaining index once index i is struck out.
  function automatic logic [SIZE_W-1:0] skip_hi(input logic [SIZE_W-1:0] i);
    skip_hi = (i == 2'd2) ? 2'd1 : 2'd2;
  endfunction

endpackage

@@ design/smdc_lane.sv @@
// ----------------------------------------------------------------------------
// smdc_lane: one 2x2 minor lane
// Registers a*d and c*b, takes their difference, then weights the minor by
// one element. Also hands the bare minor forward aligned with the product.
// ----------------------------------------------------------------------------
module smdc_lane
  import smdc_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [ELEM_BITS-1:0]  a,
  input  logic signed [ELEM_BITS-1:0]  b,
  input  logic signed [ELEM_BITS-1:0]  c,
  input  logic signed [ELEM_BITS-1:0]  d,
  input  logic signed [ELEM_BITS-1:0]  w,
  output logic signed [3*ELEM_BITS:0]  prod,
  output logic signed [2*ELEM_BITS:0]  minor
);

  logic signed [2*ELEM_BITS-1:0] ad;
  logic signed [2*ELEM_BITS-1:0] cb;
  logic signed [ELEM_BITS-1:0]   w1;
  logic signed [ELEM_BITS-1:0]   w2;
  logic signed [2*ELEM_BITS:0]   minor_s;

  always_ff @(posedge clk) begin
    ad      <= a * d;
    cb      <= c * b;
    w1      <= w;
    minor_s <= ad - cb;
    w2      <= w1;
    prod    <= w2 * minor_s;
    minor   <= minor_s;
  end

endmodule

@@ design/smdc_merge.sv @@
// ----------------------------------------------------------------------------
// smdc_merge: result merge stage
// Combines the lane products into the determinant, or picks the cofactor,
// scales it to the output fraction width and drives the result word.
// ----------------------------------------------------------------------------
module smdc_merge
  import smdc_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctrl_t                         ctrl,
  input  logic signed [ELEM_BITS-1:0]   scalar,
  input  logic signed [3*ELEM_BITS:0]   prod [NUM_LANES],
  input  logic signed [2*ELEM_BITS:0]   minor0,
  output logic                          done,
  output logic signed [VALUE_BITS-1:0]  value,
  output logic                          bad_index
);

  localparam int SUM_W = 3 * ELEM_BITS + 3;

  logic signed [SUM_W-1:0]      det3;
  logic signed [VALUE_BITS-1:0] one_v;
  logic signed [VALUE_BITS-1:0] elem_v;
  logic signed [VALUE_BITS-1:0] minor_v;
  logic signed [VALUE_BITS-1:0] value_next;

  always_comb begin
    det3    = SUM_W'(prod[0]) - SUM_W'(prod[1]) + SUM_W'(prod[2]);
    one_v   = VALUE_BITS'(1) <<< (3 * FRAC_BITS);
    elem_v  = VALUE_BITS'(scalar) <<< (2 * FRAC_BITS);
    minor_v = VALUE_BITS'(minor0) <<< FRAC_BITS;
    if (ctrl.op == OP_DET) begin
      case (ctrl.size)
        2'd0:    value_next = one_v;
        2'd1:    value_next = elem_v;
        2'd2:    value_next = minor_v;
        default: value_next = VALUE_BITS'(det3);
      endcase
    end else if (ctrl.bad) begin
      value_next = '0;
    end else begin
      case (ctrl.size)
        2'd1:    value_next = one_v;
        2'd2:    value_next = elem_v;
        default: value_next = minor_v;
      endcase
      if (ctrl.neg) begin
        value_next = -value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.valid;
    end
    value     <= value_next;
    bad_index <= ctrl.bad;
  end

endmodule

@@ design/small_matrix_determinant_cofactor.sv @@
// ----------------------------------------------------------------------------
// small_matrix_determinant_cofactor: determinant / cofactor of a 3x3 matrix
// Usage:
//   Command channel: drive opcode, sel_row, sel_col and the nine elements
//   with start high. A word is taken at every rising edge where start is
//   high and busy is low. busy never rises, so a new matrix may enter on
//   every cycle: throughput is one word per clock.
//   Result channel: done strobes for one cycle with value and bad_index.
//   The result of a command passes two multiplier stages, one subtract
//   stage and the merge register before done rises. Results leave in
//   command order. The receiver cannot stall; it must take each result
//   in the cycle that done is high.
//   Config channel: cfg_valid / cfg_ready carry matrix_size in cfg_data.
//   cfg_ready is always high. Change it only while no command is in flight.
//   Reset (rst, synchronous) empties the pipeline and sets matrix_size to 3.
// Structure: three minor lanes run side by side. Lane 0 forms the selected
// minor (cofactor, or the leading 2x2 determinant); lanes 0..2 together form
// the column-0 expansion of the 3x3 determinant. A merge stage adds the lane
// products and scales the result to 3*FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module small_matrix_determinant_cofactor
  import smdc_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [SIZE_W-1:0]             sel_row,
  input  logic [SIZE_W-1:0]             sel_col,
  input  logic signed [ELEM_W-1:0]      elem_r0c0,
  input  logic signed [ELEM_W-1:0]      elem_r0c1,
  input  logic signed [ELEM_W-1:0]      elem_r0c2,
  input  logic signed [ELEM_W-1:0]      elem_r1c0,
  input  logic signed [ELEM_W-1:0]      elem_r1c1,
  input  logic signed [ELEM_W-1:0]      elem_r1c2,
  input  logic signed [ELEM_W-1:0]      elem_r2c0,
  input  logic signed [ELEM_W-1:0]      elem_r2c1,
  input  logic signed [ELEM_W-1:0]      elem_r2c2,
  // result channel
  output logic                          done,
  output logic signed [VALUE_BITS-1:0]  value,
  output logic                          bad_index,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [SIZE_W-1:0]             cfg_data
);

  logic [SIZE_W-1:0] matrix_size;

  // Elements trimmed to their low ELEM_BITS bits, as a 3x3 grid.
  logic signed [ELEM_BITS-1:0] m [3][3];

  logic signed [ELEM_BITS-1:0] la [NUM_LANES];
  logic signed [ELEM_BITS-1:0] lb [NUM_LANES];
  logic signed [ELEM_BITS-1:0] lc [NUM_LANES];
  logic signed [ELEM_BITS-1:0] ld [NUM_LANES];
  logic signed [ELEM_BITS-1:0] lw [NUM_LANES];
  logic signed [3*ELEM_BITS:0] lprod  [NUM_LANES];
  logic signed [2*ELEM_BITS:0] lminor [NUM_LANES];

  logic [SIZE_W-1:0] r0, r1, c0, c1;
  logic              take;
  ctrl_t             ctrl_in, ctrl1, ctrl2, ctrl3;
  logic signed [ELEM_BITS-1:0] scalar_in, scalar1, scalar2, scalar3;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  always_comb begin
    m[0][0] = elem_r0c0[ELEM_BITS-1:0];
    m[0][1] = elem_r0c1[ELEM_BITS-1:0];
    m[0][2] = elem_r0c2[ELEM_BITS-1:0];
    m[1][0] = elem_r1c0[ELEM_BITS-1:0];
    m[1][1] = elem_r1c1[ELEM_BITS-1:0];
    m[1][2] = elem_r1c2[ELEM_BITS-1:0];
    m[2][0] = elem_r2c0[ELEM_BITS-1:0];
    m[2][1] = elem_r2c1[ELEM_BITS-1:0];
    m[2][2] = elem_r2c2[ELEM_BITS-1:0];
  end

  // Lane 0 minor position: the selected element for a 3x3 cofactor, the
  // leading 2x2 block (strike row 2, column 2) for a 2x2 determinant,
  // and column 0 row 0 for the 3x3 expansion.
  always_comb begin
    if (opcode == OP_COF && matrix_size == 2'd3) begin
      r0 = skip_lo(sel_row);
      r1 = skip_hi(sel_row);
      c0 = skip_lo(sel_col);
      c1 = skip_hi(sel_col);
    end else if (opcode == OP_DET && matrix_size == 2'd2) begin
      r0 = 2'd0;
      r1 = 2'd1;
      c0 = 2'd0;
      c1 = 2'd1;
    end else begin
      r0 = 2'd1;
      r1 = 2'd2;
      c0 = 2'd1;
      c1 = 2'd2;
    end
  end

  always_comb begin
    la[0] = m[r0][c0];
    lb[0] = m[r0][c1];
    lc[0] = m[r1][c0];
    ld[0] = m[r1][c1];
    lw[0] = m[0][0];
    // Row 1, column 0 minor
    la[1] = m[0][1];
    lb[1] = m[0][2];
    lc[1] = m[2][1];
    ld[1] = m[2][2];
    lw[1] = m[1][0];
    // Row 2, column 0 minor
    la[2] = m[0][1];
    lb[2] = m[0][2];
    lc[2] = m[1][1];
    ld[2] = m[1][2];
    lw[2] = m[2][0];
  end

  // Single-element path: m00 for a 1x1 determinant, the opposite element
  // for a 2x2 cofactor.
  always_comb begin
    if (opcode == OP_DET) begin
      scalar_in = m[0][0];
    end else begin
      scalar_in = m[{1'b0, ~sel_row[0]}][{1'b0, ~sel_col[0]}];
    end
    ctrl_in.valid = take;
    ctrl_in.op    = op_t'(opcode);
    ctrl_in.size  = matrix_size;
    ctrl_in.bad   = (opcode == OP_COF) &&
                    (sel_row >= matrix_size || sel_col >= matrix_size);
    ctrl_in.neg   = sel_row[0] ^ sel_col[0];
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    smdc_lane #(
      .ELEM_BITS (ELEM_BITS)
    ) u_lane (
      .clk   (clk),
      .a     (la[g]),
      .b     (lb[g]),
      .c     (lc[g]),
      .d     (ld[g]),
      .w     (lw[g]),
      .prod  (lprod[g]),
      .minor (lminor[g])
    );
  end

  // Hold the size register; advance the control word alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size  <= SIZE_RESET;
      ctrl1.valid  <= 1'b0;
      ctrl2.valid  <= 1'b0;
      ctrl3.valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        matrix_size <= cfg_data;
      end
      ctrl1.valid <= ctrl_in.valid;
      ctrl2.valid <= ctrl1.valid;
      ctrl3.valid <= ctrl2.valid;
    end
    ctrl1.op   <= ctrl_in.op;
    ctrl1.size <= ctrl_in.size;
    ctrl1.bad  <= ctrl_in.bad;
    ctrl1.neg  <= ctrl_in.neg;
    ctrl2.op   <= ctrl1.op;
    ctrl2.size <= ctrl1.size;
    ctrl2.bad  <= ctrl1.bad;
    ctrl2.neg  <= ctrl1.neg;
    ctrl3.op   <= ctrl2.op;
    ctrl3.size <= ctrl2.size;
    ctrl3.bad  <= ctrl2.bad;
    ctrl3.neg  <= ctrl2.neg;
    scalar1    <= scalar_in;
    scalar2    <= scalar1;
    scalar3    <= scalar2;
  end

  smdc_merge #(
    .ELEM_BITS (ELEM_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl3),
    .scalar    (scalar3),
    .prod      (lprod),
    .minor0    (lminor[0]),
    .done      (done),
    .value     (value),
    .bad_index (bad_index)
  );

endmodule
